### rtl/lesq_pkg.sv
// shared constants, field widths and register index codes for the empty square finder
`default_nettype none

package lesq_pkg;

    // default map limits
    localparam int LESQ_MAX_COLS = 1024;
    localparam int LESQ_MAX_ROWS = 1024;

    // field widths
    localparam int CELL_W     = 8;
    localparam int CNT_W      = 11;
    localparam int ROW_W      = 10;
    localparam int COL_W      = 10;
    localparam int SIZE_W     = 11;
    localparam int CFG_IDX_W  = 2;
    localparam int SQ_W       = ROW_W + COL_W + SIZE_W;
    localparam int OUT_DATA_W = ((SQ_W + 7) / 8) * 8;

    // reset values of the registers
    localparam logic [CNT_W-1:0]  ROW_COUNT_RST = CNT_W'(1);
    localparam logic [CNT_W-1:0]  COL_COUNT_RST = CNT_W'(1);
    localparam logic [CELL_W-1:0] OBSTACLE_RST  = CELL_W'(111);

    // register index codes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ROW_COUNT     = 2'd0,
        CFG_COLUMN_COUNT  = 2'd1,
        CFG_OBSTACLE_CHAR = 2'd2
    } t_cfg_index;

endpackage

`default_nettype wire

### rtl/lesq_line_mem.sv
// single port write, single port read line buffer with registered read data
`default_nettype none

module lesq_line_mem #(
    parameter int DEPTH = 1024,
    parameter int AW    = 10,
    parameter int DW    = 11
) (
    input  wire logic          i_clk,
    input  wire logic          i_wr_en,
    input  wire logic [AW-1:0] i_wr_addr,
    input  wire logic [DW-1:0] i_wr_data,
    input  wire logic          i_rd_en,
    input  wire logic [AW-1:0] i_rd_addr,
    output logic      [DW-1:0] o_rd_data
);

    logic [DW-1:0] r_mem [DEPTH];

    // write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // read port, old data on a same-address collision
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

`default_nettype wire

### rtl/largest_empty_square_finder.sv
// top level: streaming largest obstacle-free square search over a byte map
//
// Cells enter on the s_axis channel, one byte per beat, in row-major order.
// A byte equal to obstacle_char is an obstacle, any other byte is free.
// After row_count * column_count beats one result beat leaves on m_axis:
// top-left row, top-left column and side of the largest free square
// (side 0 at position 0,0 when every cell is an obstacle); the scan state
// then clears itself for the next map.
// The cfg channel writes row_count, column_count and obstacle_char by index;
// it is always ready and is meant to be used between items.
// Throughput: one cell per cycle unless a stalled result holds the input stage.
// The previous row's square sides live in a one-read, one-write line buffer;
// each cell does one read and one write. The last cell passes the input stage
// and then loads the result register. A fill count of written columns stands in
// for clearing the line buffer, so no clearing pass is needed after reset or
// between maps. Reset restores the register defaults and clears the scan state.
// If m_axis stalls, the result is held; the cell that ends the next map
// waits in the input stage and s_axis tready drops until the result is taken.
`default_nettype none

module largest_empty_square_finder #(
    parameter int MAX_COLS = lesq_pkg::LESQ_MAX_COLS,
    parameter int MAX_ROWS = lesq_pkg::LESQ_MAX_ROWS
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    // cell stream
    input  wire logic                              i_s_axis_tvalid,
    output logic                                   o_s_axis_tready,
    input  wire logic [lesq_pkg::CELL_W-1:0]       i_s_axis_tdata,  // [7:0] cell_byte
    // result stream
    output logic                                   o_m_axis_tvalid,
    input  wire logic                              i_m_axis_tready,
    // [9:0] square_row, [19:10] square_col, [30:20] square_size, [31] zero
    output logic      [lesq_pkg::OUT_DATA_W-1:0]   o_m_axis_tdata,
    // register writes
    input  wire logic                              i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  wire logic [lesq_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  wire logic [lesq_pkg::CNT_W-1:0]        i_cfg_data
);

    import lesq_pkg::*;

    localparam int CW  = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int RW  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int CCW = $clog2(MAX_COLS + 1);
    localparam int RCW = $clog2(MAX_ROWS + 1);
    localparam int SW  = CCW;
    localparam int XW  = ((CCW > RCW) ? CCW : RCW) + 1;

    // configuration registers
    logic [CNT_W-1:0]  r_row_count;
    logic [CNT_W-1:0]  r_col_count;
    logic [CELL_W-1:0] r_obstacle;

    // input side position and fill count of the line buffer
    logic [CW-1:0]     r_cur_col;
    logic [RW-1:0]     r_cur_row;
    logic [CCW-1:0]    r_hwm;

    // input stage
    logic              r_s1_valid;
    logic [CELL_W-1:0] r_s1_cell;
    logic [CW-1:0]     r_s1_col;
    logic [RW-1:0]     r_s1_row;
    logic              r_s1_row_end;
    logic              r_s1_map_end;
    logic              r_s1_up_vld;
    logic              r_s1_fwd;
    logic [SW-1:0]     r_fwd_val;

    // scan state
    logic [SW-1:0]     r_left;
    logic [SW-1:0]     r_diag;
    logic [SW-1:0]     r_best_size;
    logic [RW-1:0]     r_best_row;
    logic [CW-1:0]     r_best_col;

    // result register
    logic              r_out_valid;
    logic [ROW_W-1:0]  r_out_row;
    logic [COL_W-1:0]  r_out_col;
    logic [SIZE_W-1:0] r_out_size;

    logic [CCW-1:0]    eff_cols;
    logic [RCW-1:0]    eff_rows;
    logic [XW-1:0]     in_col_p1;
    logic [XW-1:0]     in_row_p1;
    logic              in_row_end;
    logic              in_map_end;
    logic              in_up_vld;
    logic              s_accept;
    logic              out_free;
    logic              s1_fire;
    logic [SW-1:0]     mem_q;
    logic [SW-1:0]     up;
    logic [SW-1:0]     left;
    logic [SW-1:0]     diag;
    logic [SW-1:0]     min_ul;
    logic [SW-1:0]     min_all;
    logic [SW-1:0]     v;
    logic              better;
    logic [XW-1:0]     top_row_x;
    logic [XW-1:0]     top_col_x;
    logic [SW-1:0]     n_best_size;
    logic [RW-1:0]     n_best_row;
    logic [CW-1:0]     n_best_col;

    // register writes, unknown index ignored
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_count <= ROW_COUNT_RST;
            r_col_count <= COL_COUNT_RST;
            r_obstacle  <= OBSTACLE_RST;
        end else if (i_cfg_valid) begin
            unique case (t_cfg_index'(i_cfg_index))
                CFG_ROW_COUNT:     r_row_count <= i_cfg_data;
                CFG_COLUMN_COUNT:  r_col_count <= i_cfg_data;
                CFG_OBSTACLE_CHAR: r_obstacle  <= i_cfg_data[CELL_W-1:0];
                default: ;
            endcase
        end
    end

    // clamp the counts to 1..max
    always_comb begin
        if (r_col_count == '0) begin
            eff_cols = CCW'(1);
        end else if (int'(r_col_count) > MAX_COLS) begin
            eff_cols = CCW'(MAX_COLS);
        end else begin
            eff_cols = CCW'(r_col_count);
        end
        if (r_row_count == '0) begin
            eff_rows = RCW'(1);
        end else if (int'(r_row_count) > MAX_ROWS) begin
            eff_rows = RCW'(MAX_ROWS);
        end else begin
            eff_rows = RCW'(r_row_count);
        end
    end

    // handshakes
    assign out_free        = !r_out_valid || i_m_axis_tready;
    assign s1_fire         = r_s1_valid && (!r_s1_map_end || out_free);
    assign o_s_axis_tready = !r_s1_valid || s1_fire;
    assign s_accept        = i_s_axis_tvalid && o_s_axis_tready;

    // row and map end of the arriving cell
    assign in_col_p1  = XW'(r_cur_col) + XW'(1);
    assign in_row_p1  = XW'(r_cur_row) + XW'(1);
    assign in_row_end = in_col_p1 >= XW'(eff_cols);
    assign in_map_end = in_row_end && (in_row_p1 >= XW'(eff_rows));
    // column already written in this map
    assign in_up_vld  = XW'(r_cur_col) < XW'(r_hwm);

    // position counters and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_col <= '0;
            r_cur_row <= '0;
            r_hwm     <= '0;
        end else if (s_accept) begin
            if (in_map_end) begin
                r_cur_col <= '0;
                r_cur_row <= '0;
                r_hwm     <= '0;
            end else begin
                if (in_row_end) begin
                    r_cur_col <= '0;
                    r_cur_row <= in_row_p1[RW-1:0];
                end else begin
                    r_cur_col <= in_col_p1[CW-1:0];
                end
                if (in_col_p1 > XW'(r_hwm)) begin
                    r_hwm <= in_col_p1[CCW-1:0];
                end
            end
        end
    end

    // input stage valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (s_accept) begin
            r_s1_valid <= 1'b1;
        end else if (s1_fire) begin
            r_s1_valid <= 1'b0;
        end
    end

    // input stage payload
    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_s1_cell    <= i_s_axis_tdata;
            r_s1_col     <= r_cur_col;
            r_s1_row     <= r_cur_row;
            r_s1_row_end <= in_row_end;
            r_s1_map_end <= in_map_end;
            r_s1_up_vld  <= in_up_vld;
            r_s1_fwd     <= s1_fire && (r_s1_col == r_cur_col);
        end
        if (s1_fire) begin
            r_fwd_val <= v;
        end
    end

    // previous row's square sides
    lesq_line_mem #(
        .DEPTH (MAX_COLS),
        .AW    (CW),
        .DW    (SW)
    ) u_line_mem (
        .i_clk     (i_clk),
        .i_wr_en   (s1_fire),
        .i_wr_addr (r_s1_col),
        .i_wr_data (v),
        .i_rd_en   (s_accept),
        .i_rd_addr (r_cur_col),
        .o_rd_data (mem_q)
    );

    // neighbor sides, zero outside the grid
    assign up   = !r_s1_up_vld ? '0 : (r_s1_fwd ? r_fwd_val : mem_q);
    assign left = (r_s1_col == '0) ? '0 : r_left;
    assign diag = ((r_s1_col == '0) || (r_s1_row == '0)) ? '0 : r_diag;

    // side of the square ending at this cell
    assign min_ul  = (left < up) ? left : up;
    assign min_all = (diag < min_ul) ? diag : min_ul;
    assign v       = (r_s1_cell == r_obstacle) ? '0 : SW'(min_all + SW'(1));

    // best square update, strictly larger only
    assign better    = v > r_best_size;
    assign top_row_x = XW'(r_s1_row) + XW'(1) - XW'(v);
    assign top_col_x = XW'(r_s1_col) + XW'(1) - XW'(v);

    always_comb begin
        if (better) begin
            n_best_size = v;
            n_best_row  = top_row_x[RW-1:0];
            n_best_col  = top_col_x[CW-1:0];
        end else begin
            n_best_size = r_best_size;
            n_best_row  = r_best_row;
            n_best_col  = r_best_col;
        end
    end

    // scan state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left      <= '0;
            r_diag      <= '0;
            r_best_size <= '0;
            r_best_row  <= '0;
            r_best_col  <= '0;
        end else if (s1_fire) begin
            if (r_s1_map_end) begin
                r_left      <= '0;
                r_diag      <= '0;
                r_best_size <= '0;
                r_best_row  <= '0;
                r_best_col  <= '0;
            end else begin
                r_best_size <= n_best_size;
                r_best_row  <= n_best_row;
                r_best_col  <= n_best_col;
                if (r_s1_row_end) begin
                    r_left <= '0;
                    r_diag <= '0;
                end else begin
                    r_left <= v;
                    r_diag <= up;
                end
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_fire && r_s1_map_end) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_fire && r_s1_map_end) begin
            r_out_row  <= ROW_W'(n_best_row);
            r_out_col  <= COL_W'(n_best_col);
            r_out_size <= SIZE_W'(n_best_size);
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {{(OUT_DATA_W - SQ_W){1'b0}}, r_out_size, r_out_col, r_out_row};

    // row 0 never sees a written column of its own map
    a_row0_no_up: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_accept && (r_cur_row == '0)) |-> !in_up_vld)
        else $error("line buffer entry valid in first row");

    // a stalled cell stays in the input stage
    a_s1_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && !s1_fire) |=> (r_s1_valid && $stable(r_s1_col) && $stable(r_s1_row)))
        else $error("input stage lost a stalled cell");

    // map end loads a result and clears the best square
    a_map_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s1_fire && r_s1_map_end) |=> (r_out_valid && (r_best_size == '0) && (r_left == '0)))
        else $error("map end did not hand off the result");

    // a pending result is never overwritten
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_m_axis_tready) |-> !(s1_fire && r_s1_map_end))
        else $error("result overwritten while stalled");

endmodule

`default_nettype wire

### tb/largest_empty_square_finder_tb.sv
// self-checking testbench for the largest empty square finder: random maps, stalls, checks
`default_nettype none

module largest_empty_square_finder_tb;
    import lesq_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SETTLE_CYCLES  = 4;
    localparam int DRAIN_CYCLES   = 20;
    localparam int RANDOM_CELLS   = 840;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_INDEX = 2'd3;

    typedef enum logic {BEAT_CELL, BEAT_CFG} t_beat_kind;

    typedef struct {
        t_beat_kind           kind;
        logic [CFG_IDX_W-1:0] idx;
        logic [CNT_W-1:0]     data;
        logic [CELL_W-1:0]    cell_byte;
    } t_stim_beat;

    typedef struct {
        logic [ROW_W-1:0]  sq_row;
        logic [COL_W-1:0]  sq_col;
        logic [SIZE_W-1:0] sq_size;
    } t_square;

    // clock, reset and block inputs
    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   cell_tvalid = 1'b0;
    logic [CELL_W-1:0]      cell_tdata = '0;
    logic                   sq_tready = 1'b0;
    logic                   cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0]   cfg_index = '0;
    logic [CNT_W-1:0]       cfg_data = '0;
    logic                   o_s_axis_tready;
    logic                   o_m_axis_tvalid;
    logic [OUT_DATA_W-1:0]  o_m_axis_tdata;
    logic                   o_cfg_ready;

    largest_empty_square_finder DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (cell_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (cell_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (sq_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .i_cfg_valid     (cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // stimulus and expected squares
    t_stim_beat        pending_beats[$];
    t_square           pending_squares[$];
    t_stim_beat        head_beat;
    logic [CELL_W-1:0] gen_obst = OBSTACLE_RST;
    int                gen_cells = 0;

    // shadow registers and scan state of the predictor
    logic [CNT_W-1:0]  map_rows_reg;
    logic [CNT_W-1:0]  map_cols_reg;
    logic [CELL_W-1:0] obstacle_reg;
    logic [SIZE_W-1:0] prev_row_sides [LESQ_MAX_COLS];
    logic [SIZE_W-1:0] left_side;
    logic [SIZE_W-1:0] diag_side;
    logic [ROW_W-1:0]  scan_row;
    logic [COL_W-1:0]  scan_col;
    logic [SIZE_W-1:0] best_side;
    logic [ROW_W-1:0]  best_top;
    logic [COL_W-1:0]  best_left;

    // bookkeeping
    int   fail_count = 0;
    int   cells_accepted = 0;
    int   maps_scanned = 0;
    int   results_got = 0;
    int   quiet_cycles = 0;
    int   gap_left = 0;
    int   send_calm = 0;
    int   recv_calm = 0;
    int   rdy_wait = 0;
    int   stall_cycles = 0;
    bit   cell_take, cfg_take, next_cell_vld, next_cfg_vld, next_rdy;

    function automatic int clamp_count(input int v, input int hi);
        if (v < 1) return 1;
        if (v > hi) return hi;
        return v;
    endfunction

    // wait before the next beat; sometimes a run of back-to-back beats
    function automatic int draw_wait(inout int calm);
        if (calm > 0) begin
            calm--;
            return 0;
        end
        if ($urandom_range(0, 29) == 0) begin
            calm = $urandom_range(10, 60);
            return 0;
        end
        return $urandom_range(0, 17);
    endfunction

    task automatic clear_scan();
        for (int i = 0; i < LESQ_MAX_COLS; i++) prev_row_sides[i] = '0;
        left_side = '0;
        diag_side = '0;
        scan_row  = '0;
        scan_col  = '0;
        best_side = '0;
        best_top  = '0;
        best_left = '0;
    endtask

    task automatic write_shadow_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CNT_W-1:0] data);
        case (idx)
            CFG_ROW_COUNT:     map_rows_reg = data;
            CFG_COLUMN_COUNT:  map_cols_reg = data;
            CFG_OBSTACLE_CHAR: obstacle_reg = data[CELL_W-1:0];
            default: ;
        endcase
    endtask

    // one cell of the scan: square side ending here, best square, map end
    task automatic scan_cell(input logic [CELL_W-1:0] cell_byte);
        int      rows, cols, c, up, lft, dg, side;
        t_square sq;
        rows = clamp_count(map_rows_reg, LESQ_MAX_ROWS);
        cols = clamp_count(map_cols_reg, LESQ_MAX_COLS);
        c = scan_col;
        if (c >= LESQ_MAX_COLS) c = LESQ_MAX_COLS - 1;
        up  = (scan_row == 0) ? 0 : int'(prev_row_sides[c]);
        lft = (c == 0) ? 0 : int'(left_side);
        dg  = (c == 0 || scan_row == 0) ? 0 : int'(diag_side);
        if (cell_byte == obstacle_reg) begin
            side = 0;
        end else begin
            side = up;
            if (lft < side) side = lft;
            if (dg < side) side = dg;
            side = side + 1;
        end
        // strictly larger only, so the first corner in row-major order wins ties
        if (side > int'(best_side)) begin
            best_side = SIZE_W'(side);
            best_top  = ROW_W'(int'(scan_row) + 1 - side);
            best_left = COL_W'(c + 1 - side);
        end
        diag_side = SIZE_W'(up);
        prev_row_sides[c] = SIZE_W'(side);
        left_side = SIZE_W'(side);
        if (c + 1 >= cols && int'(scan_row) + 1 >= rows) begin
            sq.sq_row  = best_top;
            sq.sq_col  = best_left;
            sq.sq_size = best_side;
            pending_squares.push_back(sq);
            maps_scanned++;
            clear_scan();
        end else if (c + 1 >= cols) begin
            scan_col  = '0;
            scan_row  = scan_row + 1'b1;
            left_side = '0;
            diag_side = '0;
        end else begin
            scan_col = COL_W'(c + 1);
        end
    endtask

    task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
        if (got !== want) begin
            $error("%s expected %0d got %0d", name, want, got);
            fail_count++;
        end
    endtask

    task automatic check_square(input logic [OUT_DATA_W-1:0] beat);
        t_square want;
        if (pending_squares.size() == 0) begin
            $error("result beat %h with no square expected", beat);
            fail_count++;
        end else begin
            want = pending_squares.pop_front();
            check_field("square_row", want.sq_row, beat[ROW_W-1:0]);
            check_field("square_col", want.sq_col, beat[ROW_W +: COL_W]);
            check_field("square_size", want.sq_size, beat[ROW_W+COL_W +: SIZE_W]);
            check_field("tdata pad", 0, beat[OUT_DATA_W-1:SQ_W]);
        end
    endtask

    // stimulus builders
    task automatic add_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [CNT_W-1:0] data);
        t_stim_beat b;
        b.kind      = BEAT_CFG;
        b.idx       = idx;
        b.data      = data;
        b.cell_byte = '0;
        pending_beats.push_back(b);
        if (idx == CFG_OBSTACLE_CHAR) gen_obst = data[CELL_W-1:0];
    endtask

    task automatic add_cell(input logic [CELL_W-1:0] cell_byte);
        t_stim_beat b;
        b.kind      = BEAT_CELL;
        b.idx       = '0;
        b.data      = '0;
        b.cell_byte = cell_byte;
        pending_beats.push_back(b);
    endtask

    function automatic logic [CELL_W-1:0] pick_free_byte();
        logic [CELL_W-1:0] b;
        b = CELL_W'($urandom_range(0, 255));
        if (b == gen_obst) b = ~b;
        return b;
    endfunction

    // whole map; lone_idx >= 0 leaves one free cell among obstacles
    task automatic add_map(input int rows_w, input int cols_w, input int obst_pct,
                           input int lone_idx);
        int n;
        n = clamp_count(rows_w, LESQ_MAX_ROWS) * clamp_count(cols_w, LESQ_MAX_COLS);
        add_cfg(CFG_ROW_COUNT, CNT_W'(rows_w));
        add_cfg(CFG_COLUMN_COUNT, CNT_W'(cols_w));
        for (int i = 0; i < n; i++) begin
            if (lone_idx >= 0)
                add_cell((i == lone_idx) ? pick_free_byte() : gen_obst);
            else if ($urandom_range(0, 99) < obst_pct)
                add_cell(gen_obst);
            else
                add_cell(pick_free_byte());
        end
        gen_cells += n;
    endtask

    // driver: cell and register beats from the pending queue
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cell_tvalid <= 1'b0;
            cfg_valid   <= 1'b0;
            gap_left = 0;
            quiet_cycles = 0;
            map_rows_reg = ROW_COUNT_RST;
            map_cols_reg = COL_COUNT_RST;
            obstacle_reg = OBSTACLE_RST;
            clear_scan();
        end else begin
            cell_take = cell_tvalid && o_s_axis_tready;
            cfg_take  = cfg_valid && o_cfg_ready;
            next_cell_vld = cell_tvalid && !cell_take;
            next_cfg_vld  = cfg_valid && !cfg_take;
            if (cell_take) begin
                scan_cell(cell_tdata);
                cells_accepted++;
            end
            if (cfg_take) write_shadow_reg(cfg_index, cfg_data);
            // register writes only once every map's square is back and settled
            if (results_got == maps_scanned) quiet_cycles++;
            else quiet_cycles = 0;
            if (!next_cell_vld && !next_cfg_vld && pending_beats.size() != 0) begin
                if (gap_left != 0) begin
                    gap_left--;
                end else if (pending_beats[0].kind == BEAT_CELL) begin
                    head_beat = pending_beats.pop_front();
                    cell_tdata <= head_beat.cell_byte;
                    next_cell_vld = 1'b1;
                    gap_left = draw_wait(send_calm);
                end else if (quiet_cycles >= SETTLE_CYCLES) begin
                    head_beat = pending_beats.pop_front();
                    cfg_index <= head_beat.idx;
                    cfg_data  <= head_beat.data;
                    next_cfg_vld = 1'b1;
                    gap_left = draw_wait(send_calm);
                end
            end
            cell_tvalid <= next_cell_vld;
            cfg_valid   <= next_cfg_vld;
        end
    end

    // monitor: result beats with random backpressure
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            sq_tready   <= 1'b0;
            results_got <= 0;
            rdy_wait = 0;
        end else begin
            next_rdy = sq_tready;
            if (sq_tready && o_m_axis_tvalid) begin
                check_square(o_m_axis_tdata);
                results_got <= results_got + 1;
                rdy_wait = draw_wait(recv_calm);
                if (rdy_wait != 0) next_rdy = 1'b0;
            end else if (!sq_tready) begin
                if (rdy_wait > 0) rdy_wait--;
                if (rdy_wait == 0) next_rdy = 1'b1;
            end
            sq_tready <= next_rdy;
        end
    end

    // watchdog on cycles with no beat moving
    always @(posedge i_clk) begin
        if (!i_rst_n || (cell_tvalid && o_s_axis_tready) || (cfg_valid && o_cfg_ready) ||
            (sq_tready && o_m_axis_tvalid)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= WATCHDOG_LIMIT) begin
            $error("no beat moved for %0d cycles", stall_cycles);
            $display("FAIL largest_empty_square_finder");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    // stimulus, reset and end of run
    initial begin
        int rows_w, cols_w, pct;

        // reset defaults: 1x1 map, obstacle byte 111
        add_cell(OBSTACLE_RST);
        add_cell(8'h00);
        // unknown register index leaves everything as it was
        add_cfg(CFG_UNUSED_INDEX, 11'h7ff);
        add_cell(OBSTACLE_RST);
        // zero row count clamps to one; upper data bits of the obstacle write dropped
        add_cfg(CFG_ROW_COUNT, 11'd0);
        add_cfg(CFG_COLUMN_COUNT, 11'd3);
        add_cfg(CFG_OBSTACLE_CHAR, 11'h500);
        add_cell(8'h00);
        add_cell(8'hff);
        add_cell(8'h80);
        // all-free 3x3 map
        add_cfg(CFG_OBSTACLE_CHAR, 11'h0ff);
        add_cfg(CFG_ROW_COUNT, 11'd3);
        for (int i = 0; i < 8; i++) add_cell(8'(1 << i));
        add_cell(8'h7f);
        // two equal 2x2 squares split by an obstacle column; the first one wins
        add_cfg(CFG_ROW_COUNT, 11'd2);
        add_cfg(CFG_COLUMN_COUNT, 11'd5);
        for (int r = 0; r < 2; r++)
            for (int c = 0; c < 5; c++) add_cell((c == 2) ? 8'hff : 8'(r * 5 + c));

        // random maps, mostly small
        while (gen_cells < RANDOM_CELLS) begin
            if ($urandom_range(0, 3) == 0) begin
                case ($urandom_range(0, 3))
                    0: add_cfg(CFG_OBSTACLE_CHAR, {3'($urandom_range(0, 7)), 8'h00});
                    1: add_cfg(CFG_OBSTACLE_CHAR, {3'($urandom_range(0, 7)), 8'hff});
                    2: add_cfg(CFG_OBSTACLE_CHAR, {3'b000, OBSTACLE_RST});
                    default: add_cfg(CFG_OBSTACLE_CHAR, 11'($urandom_range(0, 2047)));
                endcase
            end
            rows_w = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 20) : $urandom_range(1, 6);
            cols_w = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 20) : $urandom_range(1, 8);
            if ($urandom_range(0, 19) == 0) rows_w = 0;
            if ($urandom_range(0, 19) == 0) cols_w = 0;
            pct = $urandom_range(0, 10) * 10;
            add_map(rows_w, cols_w, pct, -1);
        end

        // last small map
        add_map(3, 4, 10, -1);

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_beats.size() != 0 || cell_tvalid || cfg_valid ||
               results_got != maps_scanned)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (pending_squares.size() != 0) begin
            $error("%0d expected squares never arrived", pending_squares.size());
            fail_count++;
        end
        $display("scanned %0d cells in %0d maps, row and column counts from 0 to 20,",
                 cells_accepted, maps_scanned);
        $display("obstacle bytes varied, random gaps and backpressure on both streams");
        if (fail_count == 0) begin
            $display("PASS largest_empty_square_finder");
        end else begin
            $display("FAIL largest_empty_square_finder");
        end
        $finish;
    end

endmodule

`default_nettype wire
